@@ hdl/scx_pkg.sv @@
// ----------------------------------------------------------------------------
// scx_pkg
// Types and constants shared by the SD SPI-mode command exchange engine.
// ----------------------------------------------------------------------------
`default_nettype none

package scx_pkg;

  // Input command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_RX    = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_READY_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_POLL_LIMIT    = 2'd1;

  localparam logic [15:0] READY_TIMEOUT_RST = 16'd500;
  localparam logic [7:0]  POLL_LIMIT_RST    = 8'd10;

  // SD command constants
  localparam logic [5:0] IDX_GO_IDLE   = 6'd0;
  localparam logic [5:0] IDX_IF_COND   = 6'd8;
  localparam logic [5:0] IDX_STOP      = 6'd12;
  localparam logic [5:0] IDX_APP_CMD   = 6'd55;
  localparam logic [1:0] FRAME_START   = 2'b01;
  localparam logic [7:0] CRC_GO_IDLE   = 8'h95;
  localparam logic [7:0] CRC_IF_COND   = 8'h87;
  localparam logic [7:0] BYTE_IDLE     = 8'hFF;
  localparam logic [7:0] R1_IDLE       = 8'h01;
  localparam logic [2:0] LAST_ARG_BYTE = 3'd5;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  cmd_index;
    logic        app_cmd;
    logic [31:0] cmd_arg;
    logic [7:0]  rx_byte;
  } in_word_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select;
    logic       done_res;
    logic [7:0] resp_byte;
    logic       not_ready;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_START,
    OP_RX,
    OP_TICK
  } op_e;

  typedef struct packed {
    op_e         kind;
    logic [5:0]  cmd_index;
    logic        app_cmd;
    logic [31:0] cmd_arg;
    logic [7:0]  rx_byte;
  } op_t;

  typedef struct packed {
    logic [15:0] ready_timeout;
    logic [7:0]  poll_limit;
  } cfg_t;

endpackage

`default_nettype wire

@@ hdl/sd_spi_command_exchange.sv @@
// Path: an accepted input word is registered in the input queue, the sequencer
// step on it is combinational, and its result word is registered in the result queue.
// Throughput: one input word per cycle while the result queue is not full.
// Both queues hold two words; the input side stalls only once the result queue
// has filled and the input queue has backed up behind it.
// Reset: asynchronous, active low; queues empty, sequencer idle, CS released,
// registers at 500 ticks ready timeout and 10 response polls.
// ----------------------------------------------------------------------------
// sd_spi_command_exchange
// Host-side SD SPI-mode command engine with R1 response handling.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_spi_command_exchange (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire scx_pkg::in_word_t  in_word_i,
  output logic                    empty,
  input  wire logic               pop,
  output scx_pkg::out_word_t      out_word_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);

  localparam int ResWidth = $bits(scx_pkg::out_word_t);

  scx_pkg::cfg_t      cfg_q;
  logic               op_valid;
  scx_pkg::op_t       op;
  logic               op_pop;
  logic               res_full;
  logic               res_push;
  scx_pkg::out_word_t res;
  logic [ResWidth-1:0] res_rd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ready_timeout <= scx_pkg::READY_TIMEOUT_RST;
      cfg_q.poll_limit    <= scx_pkg::POLL_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        scx_pkg::REG_READY_TIMEOUT: cfg_q.ready_timeout <= cfg_data_i;
        scx_pkg::REG_POLL_LIMIT:    cfg_q.poll_limit    <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  scx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_word_i  (in_word_i),
    .full_o     (full),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  scx_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_pop_o   (op_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  scx_fifo #(
    .Width(ResWidth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rd),
    .empty_o (empty)
  );

  assign out_word_o = scx_pkg::out_word_t'(res_rd);

endmodule

`default_nettype wire

@@ hdl/scx_fifo.sv @@
// ----------------------------------------------------------------------------
// scx_fifo
// Two-entry register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scx_fifo #(
  parameter int Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/scx_front.sv @@
// ----------------------------------------------------------------------------
// scx_front
// Accepts input words, drops unused command codes and queues operations.
// ----------------------------------------------------------------------------
`default_nettype none

module scx_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire scx_pkg::in_word_t in_word_i,
  output logic                  full_o,
  output logic                  op_valid_o,
  output scx_pkg::op_t          op_o,
  input  wire logic             op_pop_i
);

  localparam int OpWidth = $bits(scx_pkg::op_t);

  scx_pkg::op_t       op_in;
  logic               op_known;
  logic [OpWidth-1:0] op_rd;
  logic               q_empty;

  always_comb begin
    op_in.cmd_index = in_word_i.cmd_index;
    op_in.app_cmd   = in_word_i.app_cmd;
    op_in.cmd_arg   = in_word_i.cmd_arg;
    op_in.rx_byte   = in_word_i.rx_byte;
    op_in.kind      = scx_pkg::OP_START;
    op_known        = 1'b1;
    unique case (in_word_i.command)
      scx_pkg::CMD_START: op_in.kind = scx_pkg::OP_START;
      scx_pkg::CMD_RX:    op_in.kind = scx_pkg::OP_RX;
      scx_pkg::CMD_TICK:  op_in.kind = scx_pkg::OP_TICK;
      default:            op_known   = 1'b0;
    endcase
  end

  // unused codes are accepted but never queued
  scx_fifo #(
    .Width(OpWidth)
  ) u_op_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && op_known),
    .wdata_i (op_in),
    .full_o  (full_o),
    .pop_i   (op_pop_i),
    .rdata_o (op_rd),
    .empty_o (q_empty)
  );

  assign op_valid_o = !q_empty;
  assign op_o       = scx_pkg::op_t'(op_rd);

endmodule

`default_nettype wire

@@ hdl/scx_engine.sv @@
// ----------------------------------------------------------------------------
// scx_engine
// Command sequencer: select, ready wait, frame, CMD12 discard byte, R1 poll and CMD55 prefix.
// ----------------------------------------------------------------------------
`default_nettype none

module scx_engine (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire scx_pkg::cfg_t     cfg_i,
  input  wire logic              op_valid_i,
  input  wire scx_pkg::op_t      op_i,
  output logic                   op_pop_o,
  input  wire logic              res_full_i,
  output logic                   res_push_o,
  output scx_pkg::out_word_t     res_o
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_DESEL,
    PH_SEL,
    PH_WAIT,
    PH_FAIL,
    PH_FRAME,
    PH_DISCARD,
    PH_POLL
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  byte_idx_q, byte_idx_d;
  logic [15:0] timer_q, timer_d;
  logic [7:0]  polls_q, polls_d;
  logic [5:0]  held_idx_q, held_idx_d;
  logic [31:0] held_arg_q, held_arg_d;
  logic        prefix_q, prefix_d;
  logic        cs_q, cs_d;

  logic        fire;
  logic [5:0]  cur_idx;
  logic [31:0] cur_arg;
  logic [5:0]  start_idx;
  logic [7:0]  polls_dec;
  logic        emit, fin;
  logic [7:0]  tx_byte;
  logic [7:0]  resp_byte;
  logic        not_ready;

  function automatic logic [7:0] frame_byte(input logic [5:0]  idx,
                                            input logic [31:0] arg,
                                            input logic [2:0]  sel);
    logic [7:0] b;
    b = scx_pkg::BYTE_IDLE;
    case (sel)
      3'd0: b = {scx_pkg::FRAME_START, idx};
      3'd1: b = arg[31:24];
      3'd2: b = arg[23:16];
      3'd3: b = arg[15:8];
      3'd4: b = arg[7:0];
      default: begin
        if (idx == scx_pkg::IDX_GO_IDLE) begin
          b = scx_pkg::CRC_GO_IDLE;
        end else if (idx == scx_pkg::IDX_IF_COND) begin
          b = scx_pkg::CRC_IF_COND;
        end else begin
          b = scx_pkg::BYTE_IDLE;
        end
      end
    endcase
    return b;
  endfunction

  assign fire     = op_valid_i && !res_full_i;
  assign op_pop_o = fire;
  assign cur_idx  = prefix_q ? scx_pkg::IDX_APP_CMD : held_idx_q;
  assign cur_arg  = prefix_q ? 32'd0 : held_arg_q;
  assign start_idx = op_i.app_cmd ? scx_pkg::IDX_APP_CMD : op_i.cmd_index;
  assign polls_dec = (polls_q != 8'd0) ? polls_q - 8'd1 : 8'd0;

  always_comb begin
    phase_d    = phase_q;
    byte_idx_d = byte_idx_q;
    timer_d    = timer_q;
    polls_d    = polls_q;
    held_idx_d = held_idx_q;
    held_arg_d = held_arg_q;
    prefix_d   = prefix_q;
    cs_d       = cs_q;
    emit       = 1'b0;
    fin        = 1'b0;
    tx_byte    = scx_pkg::BYTE_IDLE;
    resp_byte  = 8'd0;
    not_ready  = 1'b0;

    if (fire) begin
      unique case (op_i.kind)
        scx_pkg::OP_START: begin
          held_idx_d = op_i.cmd_index;
          held_arg_d = op_i.cmd_arg;
          prefix_d   = op_i.app_cmd;
          emit       = 1'b1;
          if (start_idx != scx_pkg::IDX_STOP) begin
            cs_d    = 1'b1;
            phase_d = PH_DESEL;
          end else begin
            byte_idx_d = 3'd0;
            phase_d    = PH_FRAME;
            tx_byte    = {scx_pkg::FRAME_START, start_idx};
          end
        end
        scx_pkg::OP_TICK: begin
          if (timer_q != 16'd0) begin
            timer_d = timer_q - 16'd1;
          end
        end
        scx_pkg::OP_RX: begin
          unique case (phase_q)
            PH_DESEL: begin
              cs_d    = 1'b0;
              phase_d = PH_SEL;
              emit    = 1'b1;
            end
            PH_SEL: begin
              timer_d = cfg_i.ready_timeout;
              phase_d = PH_WAIT;
              emit    = 1'b1;
            end
            PH_WAIT: begin
              emit = 1'b1;
              if (op_i.rx_byte == scx_pkg::BYTE_IDLE) begin
                byte_idx_d = 3'd0;
                phase_d    = PH_FRAME;
                tx_byte    = {scx_pkg::FRAME_START, cur_idx};
              end else if (timer_q == 16'd0) begin
                cs_d    = 1'b1;
                phase_d = PH_FAIL;
              end
            end
            PH_FAIL: begin
              fin       = 1'b1;
              resp_byte = scx_pkg::BYTE_IDLE;
              not_ready = 1'b1;
            end
            PH_FRAME: begin
              emit = 1'b1;
              if (byte_idx_q < scx_pkg::LAST_ARG_BYTE) begin
                byte_idx_d = byte_idx_q + 3'd1;
                tx_byte    = frame_byte(cur_idx, cur_arg, byte_idx_q + 3'd1);
              end else if (cur_idx == scx_pkg::IDX_STOP) begin
                phase_d = PH_DISCARD;
              end else begin
                polls_d = (cfg_i.poll_limit != 8'd0) ? cfg_i.poll_limit : 8'd1;
                phase_d = PH_POLL;
              end
            end
            PH_DISCARD: begin
              emit    = 1'b1;
              polls_d = (cfg_i.poll_limit != 8'd0) ? cfg_i.poll_limit : 8'd1;
              phase_d = PH_POLL;
            end
            PH_POLL: begin
              polls_d = polls_dec;
              if (op_i.rx_byte[7] && polls_dec != 8'd0) begin
                emit = 1'b1;
              end else if (prefix_q && op_i.rx_byte <= scx_pkg::R1_IDLE) begin
                // CMD55 accepted: run the application command itself
                prefix_d = 1'b0;
                emit     = 1'b1;
                if (held_idx_q != scx_pkg::IDX_STOP) begin
                  cs_d    = 1'b1;
                  phase_d = PH_DESEL;
                end else begin
                  byte_idx_d = 3'd0;
                  phase_d    = PH_FRAME;
                  tx_byte    = {scx_pkg::FRAME_START, held_idx_q};
                end
              end else begin
                fin       = 1'b1;
                resp_byte = op_i.rx_byte;
              end
            end
            default: begin
              // idle: received byte is dropped
            end
          endcase
        end
        default: begin
        end
      endcase

      if (fin) begin
        phase_d  = PH_IDLE;
        prefix_d = 1'b0;
      end
    end
  end

  assign res_push_o        = emit || fin;
  assign res_o.tx_valid    = emit;
  assign res_o.tx_byte     = emit ? tx_byte : 8'd0;
  assign res_o.chip_select = cs_d;
  assign res_o.done_res    = fin;
  assign res_o.resp_byte   = fin ? resp_byte : 8'd0;
  assign res_o.not_ready   = fin && not_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      byte_idx_q <= 3'd0;
      timer_q    <= 16'd0;
      polls_q    <= 8'd0;
      held_idx_q <= 6'd0;
      held_arg_q <= 32'd0;
      prefix_q   <= 1'b0;
      cs_q       <= 1'b1;
    end else begin
      phase_q    <= phase_d;
      byte_idx_q <= byte_idx_d;
      timer_q    <= timer_d;
      polls_q    <= polls_d;
      held_idx_q <= held_idx_d;
      held_arg_q <= held_arg_d;
      prefix_q   <= prefix_d;
      cs_q       <= cs_d;
    end
  end

endmodule

`default_nettype wire

@@ dv/sd_spi_command_exchange_tb.sv @@
// ----------------------------------------------------------------------------
// sd_spi_command_exchange_tb
// Drives start, received-byte and tick words into the SD SPI command engine
// through its input queue and checks every result word against a cycle-free
// model of the command sequencer. Register settings change between drained
// phases; both queue sides idle at random.
// ----------------------------------------------------------------------------
module sd_spi_command_exchange_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scx_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_DESEL, SEQ_SEL, SEQ_WAIT, SEQ_FAIL, SEQ_FRAME, SEQ_DISCARD, SEQ_POLL
  } seq_state_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_word_t in_word = '0;
  logic empty;
  logic pop = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  sd_spi_command_exchange DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_word_i   (in_word),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // Engine model state
  seq_state_e  eng_phase = SEQ_IDLE;
  logic [2:0]  eng_byte_idx = '0;
  logic [15:0] eng_ready_timer = '0;
  logic [7:0]  eng_polls_left = '0;
  logic [5:0]  eng_held_index = '0;
  logic [31:0] eng_held_arg = '0;
  logic        eng_prefix = 1'b0;
  logic        eng_cs = 1'b1;
  logic [15:0] model_timeout = READY_TIMEOUT_RST;
  logic [7:0]  model_poll_limit = POLL_LIMIT_RST;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];

  int queued_count = 0;
  int accepted_count = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 19;
  int recv_idle_pct = 55;
  int cfg_timeout_now = READY_TIMEOUT_RST;
  int cfg_limit_now = POLL_LIMIT_RST;
  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;

  function automatic logic [5:0] active_index();
    return eng_prefix ? IDX_APP_CMD : eng_held_index;
  endfunction

  function automatic logic [7:0] frame_byte(input logic [2:0] i);
    logic [5:0]  idx;
    logic [31:0] arg;
    idx = active_index();
    arg = eng_prefix ? 32'h0 : eng_held_arg;
    case (i)
      3'd0: return {FRAME_START, idx};
      3'd1: return arg[31:24];
      3'd2: return arg[23:16];
      3'd3: return arg[15:8];
      3'd4: return arg[7:0];
      default: begin
        if (idx == IDX_GO_IDLE) return CRC_GO_IDLE;
        if (idx == IDX_IF_COND) return CRC_IF_COND;
        return BYTE_IDLE;
      end
    endcase
  endfunction

  function automatic void send_byte(input logic [7:0] b);
    out_word_t w;
    w = '0;
    w.tx_valid = 1'b1;
    w.tx_byte = b;
    w.chip_select = eng_cs;
    expected_words.push_back(w);
  endfunction

  function automatic void complete(input logic [7:0] resp, input logic nr);
    out_word_t w;
    eng_phase = SEQ_IDLE;
    eng_prefix = 1'b0;
    w = '0;
    w.chip_select = eng_cs;
    w.done_res = 1'b1;
    w.resp_byte = resp;
    w.not_ready = nr;
    expected_words.push_back(w);
  endfunction

  function automatic void open_command();
    if (active_index() != IDX_STOP) begin
      eng_cs = 1'b1;
      eng_phase = SEQ_DESEL;
      send_byte(BYTE_IDLE);
    end else begin
      eng_byte_idx = '0;
      eng_phase = SEQ_FRAME;
      send_byte(frame_byte(3'd0));
    end
  endfunction

  function automatic void open_poll();
    eng_polls_left = (model_poll_limit != 0) ? model_poll_limit : 8'd1;
    eng_phase = SEQ_POLL;
    send_byte(BYTE_IDLE);
  endfunction

  // Advance the model by one accepted input word
  function automatic void engine_step(input in_word_t w);
    case (w.command)
      CMD_START: begin
        eng_held_index = w.cmd_index;
        eng_prefix = w.app_cmd;
        eng_held_arg = w.cmd_arg;
        open_command();
      end
      CMD_TICK: if (eng_ready_timer != 0) eng_ready_timer--;
      CMD_RX: begin
        case (eng_phase)
          SEQ_DESEL: begin
            eng_cs = 1'b0;
            eng_phase = SEQ_SEL;
            send_byte(BYTE_IDLE);
          end
          SEQ_SEL: begin
            eng_ready_timer = model_timeout;
            eng_phase = SEQ_WAIT;
            send_byte(BYTE_IDLE);
          end
          SEQ_WAIT: begin
            if (w.rx_byte == BYTE_IDLE) begin
              eng_byte_idx = '0;
              eng_phase = SEQ_FRAME;
              send_byte(frame_byte(3'd0));
            end else if (eng_ready_timer != 0) begin
              send_byte(BYTE_IDLE);
            end else begin
              eng_cs = 1'b1;
              eng_phase = SEQ_FAIL;
              send_byte(BYTE_IDLE);
            end
          end
          SEQ_FAIL: complete(BYTE_IDLE, 1'b1);
          SEQ_FRAME: begin
            if (eng_byte_idx < LAST_ARG_BYTE) begin
              eng_byte_idx++;
              send_byte(frame_byte(eng_byte_idx));
            end else if (active_index() == IDX_STOP) begin
              eng_phase = SEQ_DISCARD;
              send_byte(BYTE_IDLE);
            end else begin
              open_poll();
            end
          end
          SEQ_DISCARD: open_poll();
          SEQ_POLL: begin
            if (eng_polls_left != 0) eng_polls_left--;
            if (w.rx_byte[7] && eng_polls_left != 0) begin
              send_byte(BYTE_IDLE);
            end else if (eng_prefix) begin
              // CMD55 answered: anything above idle ends the exchange
              eng_prefix = 1'b0;
              if (w.rx_byte > R1_IDLE) complete(w.rx_byte, 1'b0);
              else open_command();
            end else begin
              complete(w.rx_byte, 1'b0);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("result word %h with nothing expected", got));
    end else begin
      want = expected_words.pop_front();
      if (got.tx_valid !== want.tx_valid)
        report_mismatch($sformatf("tx_valid %b, want %b", got.tx_valid, want.tx_valid));
      if (got.tx_byte !== want.tx_byte)
        report_mismatch($sformatf("tx_byte %h, want %h", got.tx_byte, want.tx_byte));
      if (got.chip_select !== want.chip_select)
        report_mismatch($sformatf("chip_select %b, want %b",
                                  got.chip_select, want.chip_select));
      if (got.done_res !== want.done_res)
        report_mismatch($sformatf("done_res %b, want %b", got.done_res, want.done_res));
      if (got.resp_byte !== want.resp_byte)
        report_mismatch($sformatf("resp_byte %h, want %h", got.resp_byte, want.resp_byte));
      if (got.not_ready !== want.not_ready)
        report_mismatch($sformatf("not_ready %b, want %b", got.not_ready, want.not_ready));
    end
  endtask

  // Sample handshakes, check results, feed the model
  always @(posedge clk_i) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sd_spi_command_exchange verification failed");
      $finish;
    end else begin
      cycle_count++;
      in_taken = rst_ni && push && !full;
      cfg_taken = rst_ni && cfg_valid && cfg_ready;
      if (rst_ni && pop && !empty) check_word(out_word);
      if (in_taken) begin
        engine_step(in_word);
        accepted_count++;
      end
      if (cfg_taken) begin
        if (cfg_index == REG_READY_TIMEOUT) model_timeout = cfg_data;
        else if (cfg_index == REG_POLL_LIMIT) model_poll_limit = cfg_data[7:0];
      end
    end
  end

  // Input driver: hold the word until taken, then the next one or a gap
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || in_taken) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_word <= pending_words.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic void queue_word(input logic [1:0] cmd, input logic [5:0] idx,
                                     input logic app, input logic [31:0] arg,
                                     input logic [7:0] rx);
    in_word_t w;
    w.command = cmd;
    w.cmd_index = idx;
    w.app_cmd = app;
    w.cmd_arg = arg;
    w.rx_byte = rx;
    pending_words.push_back(w);
    queued_count++;
  endfunction

  // Unused fields carry random bits; the engine must ignore them
  function automatic void queue_rx(input logic [7:0] b);
    queue_word(CMD_RX, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), $urandom, b);
  endfunction

  function automatic void queue_tick();
    queue_word(CMD_TICK, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), $urandom,
               8'($urandom_range(0, 255)));
  endfunction

  // Card-side bytes for one command: select, ready wait, frame, R1 poll
  function automatic void queue_body(input logic is_stop);
    int n;
    int busy;
    logic [7:0] resp;
    if (!is_stop) begin
      queue_rx(8'($urandom_range(0, 255)));
      queue_rx(8'($urandom_range(0, 255)));
      n = $urandom_range(0, 3);
      repeat (n) begin
        if ($urandom_range(0, 1) != 0) queue_tick();
        else queue_rx(8'($urandom_range(0, 254)));
      end
      if (cfg_timeout_now <= 8 && $urandom_range(0, 5) == 0) begin
        // let the ready timer run out, then a busy byte and the closing byte
        repeat (cfg_timeout_now) queue_tick();
        queue_rx(8'($urandom_range(0, 254)));
        queue_rx(8'($urandom_range(0, 255)));
        return;
      end
      queue_rx(BYTE_IDLE);
    end
    repeat (is_stop ? 7 : 6) queue_rx(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0) busy = (cfg_limit_now > 0) ? cfg_limit_now : 1;
    else busy = $urandom_range(0, 3);
    repeat (busy) queue_rx(8'h80 | 8'($urandom_range(0, 127)));
    case ($urandom_range(0, 2))
      0: resp = 8'h00;
      1: resp = R1_IDLE;
      default: resp = 8'($urandom_range(0, 127));
    endcase
    queue_rx(resp);
  endfunction

  function automatic void queue_exchange();
    logic [5:0] idx;
    logic app;
    case ($urandom_range(0, 6))
      0: idx = IDX_GO_IDLE;
      1: idx = IDX_IF_COND;
      2: idx = IDX_STOP;
      3: idx = IDX_APP_CMD;
      default: idx = 6'($urandom_range(0, 63));
    endcase
    app = ($urandom_range(0, 3) == 0);
    queue_word(CMD_START, idx, app, $urandom, 8'($urandom_range(0, 255)));
    if (app) queue_body(1'b0);
    queue_body(idx == IDX_STOP);
  endfunction

  function automatic void queue_random(input int count);
    int base;
    base = queued_count;
    while (queued_count - base < count) begin
      if ($urandom_range(0, 6) == 0) begin
        // noise: any code, including starts that cut an exchange short
        repeat ($urandom_range(1, 3))
          queue_word(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                     1'($urandom_range(0, 1)), $urandom, 8'($urandom_range(0, 255)));
      end else begin
        queue_exchange();
      end
    end
  endfunction

  task automatic drain();
    do @(negedge clk_i);
    while (accepted_count != queued_count || expected_words.size() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk_i);
    while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int timeout, input int limit, input int send_pct,
                           input int recv_pct);
    drain();
    write_reg(REG_READY_TIMEOUT, 16'(timeout));
    write_reg(REG_POLL_LIMIT, 16'(limit));
    cfg_timeout_now = timeout;
    cfg_limit_now = limit;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queue_random(150);
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // byte while idle, unused code, lone tick
    queue_rx(8'hAA);
    queue_word(CMD_UNUSED, 6'd63, 1'b1, 32'hFFFF_FFFF, 8'hFF);
    queue_tick();
    // CMD0 from select through R1
    queue_word(CMD_START, IDX_GO_IDLE, 1'b0, 32'h0, 8'h00);
    queue_rx(BYTE_IDLE);
    queue_rx(BYTE_IDLE);
    queue_rx(BYTE_IDLE);
    repeat (6) queue_rx(8'h00);
    queue_rx(R1_IDLE);
    // ACMD8 abandoned by CMD12, which skips select and adds the discard byte
    queue_word(CMD_START, IDX_IF_COND, 1'b1, 32'h0000_01AA, 8'h5A);
    queue_rx(8'h5A);
    queue_word(CMD_START, IDX_STOP, 1'b0, 32'hFFFF_FFFF, 8'hFF);
    repeat (7) queue_rx(8'hFF);
    queue_rx(8'h00);

    run_phase(3, 4, 19, 55);
    run_phase(65535, 255, 19, 55);
    run_phase(1, 1, 55, 19);
    run_phase(0, 0, 55, 19);
    run_phase(2, 10, 0, 0);
    run_phase(6, 2, 0, 0);
    drain();

    if (mismatch_count == 0) begin
      $display("sd_spi_command_exchange verification clean");
    end else begin
      $display("sd_spi_command_exchange verification failed");
    end
    $finish;
  end

endmodule

@@ sd_spi_command_exchange.f @@
hdl/scx_pkg.sv
hdl/scx_fifo.sv
hdl/scx_front.sv
hdl/scx_engine.sv
hdl/sd_spi_command_exchange.sv
dv/sd_spi_command_exchange_tb.sv
